// ===== rtl/mbrtu_pkg.sv =====
// ----------------------------------------------------------------------------
// Modbus RTU framer package
// Shared transaction types, request type codes, link state codes and CRC step.
// ----------------------------------------------------------------------------
package mbrtu_pkg;

    localparam int FRAME_BYTES_DEF = 256;
    localparam logic [15:0] GAP_TICKS_RESET = 16'd4000;

    // Request type codes on the input transaction.
    localparam logic [2:0] REQ_RX_BYTE  = 3'd0;
    localparam logic [2:0] REQ_TICK     = 3'd1;
    localparam logic [2:0] REQ_TX_DONE  = 3'd2;
    localparam logic [2:0] REQ_BUF_RD   = 3'd3;
    localparam logic [2:0] REQ_BUF_WR   = 3'd4;
    localparam logic [2:0] REQ_SEND     = 3'd5;
    localparam logic [2:0] REQ_NO_REPLY = 3'd6;
    localparam logic [2:0] REQ_UNUSED   = 3'd7;

    // Link state codes reported in every result.
    localparam logic [3:0] LS_IDLE  = 4'd0;
    localparam logic [3:0] LS_RECV  = 4'd1;
    localparam logic [3:0] LS_LONG  = 4'd2;
    localparam logic [3:0] LS_LERR  = 4'd3;
    localparam logic [3:0] LS_READY = 4'd4;
    localparam logic [3:0] LS_PAUSE = 4'd5;
    localparam logic [3:0] LS_DATA  = 4'd6;
    localparam logic [3:0] LS_CRCL  = 4'd7;
    localparam logic [3:0] LS_CRCH  = 4'd8;

    typedef struct packed {
        logic [2:0] req_type;
        logic [7:0] data;
        logic       line_error;
        logic [8:0] index;
        logic [8:0] length;
    } mbrtu_in_t;

    typedef struct packed {
        logic [3:0] link_state;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       driver_enable;
        logic       rx_enabled;
        logic       frame_ready;
        logic [7:0] frame_length;
        logic [7:0] read_data;
    } mbrtu_out_t;

    typedef enum logic [2:0] {
        OP_RX,
        OP_TICK,
        OP_TX_DONE,
        OP_BUF_RD,
        OP_BUF_WR,
        OP_SEND,
        OP_NO_REPLY,
        OP_NONE
    } mbrtu_op_t;

    typedef struct packed {
        mbrtu_op_t  op;
        logic [7:0] data;
        logic       line_error;
        logic [8:0] index;
        logic [8:0] length;
    } mbrtu_cmd_t;

    // One byte of CRC-16/MODBUS, reflected polynomial 0xA001.
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0] byte_in);
        logic [15:0] c;
        c = crc_in ^ {8'h00, byte_in};
        for (int b = 0; b < 8; b++)
        begin
            if (c[0])
                c = (c >> 1) ^ 16'hA001;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

// ===== rtl/mbrtu_front.sv =====
// ----------------------------------------------------------------------------
// Modbus RTU framer front end
// Accepts input transactions, decodes the request type and queues them.
// ----------------------------------------------------------------------------
module mbrtu_front
    import mbrtu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  mbrtu_in_t  in_data,
    output logic       q_valid,
    input  logic       q_pop,
    output mbrtu_cmd_t q_item
);

    mbrtu_cmd_t slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    mbrtu_cmd_t cmd;
    logic       push;
    logic       pop;

    always_comb
    begin
        cmd.data       = in_data.data;
        cmd.line_error = in_data.line_error;
        cmd.index      = in_data.index;
        cmd.length     = in_data.length;
        unique case (in_data.req_type)
            REQ_RX_BYTE:  cmd.op = OP_RX;
            REQ_TICK:     cmd.op = OP_TICK;
            REQ_TX_DONE:  cmd.op = OP_TX_DONE;
            REQ_BUF_RD:   cmd.op = OP_BUF_RD;
            REQ_BUF_WR:   cmd.op = OP_BUF_WR;
            REQ_SEND:     cmd.op = OP_SEND;
            REQ_NO_REPLY: cmd.op = OP_NO_REPLY;
            REQ_UNUSED:   cmd.op = OP_NONE;
            default:      cmd.op = OP_NONE;
        endcase
    end

    assign in_ready = (count_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (count_reg != 2'd0);
    assign pop      = q_pop && q_valid;
    assign q_item   = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

// ===== rtl/mbrtu_engine.sv =====
// ----------------------------------------------------------------------------
// Modbus RTU framer engine
// Executes queued requests against the frame store and link state.
// ----------------------------------------------------------------------------
module mbrtu_engine
    import mbrtu_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    output logic        q_pop,
    input  mbrtu_cmd_t  q_item,
    output logic        out_valid,
    input  logic        out_ready,
    output mbrtu_out_t  out_data,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data
);

    localparam int AW = $clog2(FRAME_BYTES + 1);
    localparam logic [8:0] FB9 = 9'(FRAME_BYTES);

    typedef enum logic [1:0] { S_IDLE, S_FETCH, S_WALK } state_t;

    logic [7:0] mem [FRAME_BYTES + 1];
    logic [7:0] rd_q;
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [7:0]    mem_wd;
    logic [AW-1:0] mem_ra;

    state_t      state_reg, state_next;
    logic [3:0]  mode_reg, mode_next;
    logic [8:0]  bp_reg, bp_next;
    logic [8:0]  cnt_reg, cnt_next;
    logic [15:0] crc_reg, crc_next;
    logic [15:0] gap_cnt_reg, gap_cnt_next;
    logic        gap_run_reg, gap_run_next;
    logic        drv_reg, drv_next;
    logic        rxon_reg, rxon_next;
    logic [15:0] gap_ticks_reg;
    logic        fetch_tx_reg, fetch_tx_next;
    logic        walk_chk_reg, walk_chk_next;
    logic [8:0]  issue_reg, issue_next;
    logic [8:0]  fold_reg, fold_next;
    logic [8:0]  total_reg, total_next;
    logic [8:0]  lim_reg, lim_next;
    logic        pend_reg, pend_next;
    logic [15:0] wcrc_reg, wcrc_next;
    logic [7:0]  lo_reg, lo_next;
    logic [7:0]  hi_reg, hi_next;
    logic        out_valid_reg, out_valid_next;
    mbrtu_out_t  out_reg, out_next;

    logic        slot_free;
    logic        emit;
    logic        r_txv;
    logic [7:0]  r_txb;
    logic        r_rdy;
    logic [7:0]  r_flen;
    logic [7:0]  r_rd;

    assign slot_free = !out_valid_reg || out_ready;
    assign q_pop     = (state_reg == S_IDLE) && q_valid && slot_free;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        bp_next        = bp_reg;
        cnt_next       = cnt_reg;
        crc_next       = crc_reg;
        gap_cnt_next   = gap_cnt_reg;
        gap_run_next   = gap_run_reg;
        drv_next       = drv_reg;
        rxon_next      = rxon_reg;
        fetch_tx_next  = fetch_tx_reg;
        walk_chk_next  = walk_chk_reg;
        issue_next     = issue_reg;
        fold_next      = fold_reg;
        total_next     = total_reg;
        lim_next       = lim_reg;
        pend_next      = 1'b0;
        wcrc_next      = wcrc_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;
        emit   = 1'b0;
        r_txv  = 1'b0;
        r_txb  = 8'd0;
        r_rdy  = 1'b0;
        r_flen = 8'd0;
        r_rd   = 8'd0;
        mem_we = 1'b0;
        mem_wa = '0;
        mem_wd = q_item.data;
        mem_ra = bp_reg[AW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_pop)
                begin
                    unique case (q_item.op)
                        OP_RX:
                        begin
                            emit = 1'b1;
                            if (rxon_reg)
                            begin
                                if (mode_reg == LS_IDLE || mode_reg == LS_RECV)
                                begin
                                    gap_cnt_next = gap_ticks_reg;
                                    gap_run_next = 1'b1;
                                end
                                if (q_item.line_error)
                                    mode_next = LS_LERR;
                                else if (mode_reg == LS_IDLE)
                                begin
                                    mem_we    = 1'b1;
                                    mem_wa    = '0;
                                    bp_next   = 9'd1;
                                    mode_next = LS_RECV;
                                end
                                else if (mode_reg == LS_RECV)
                                begin
                                    if (bp_reg <= FB9)
                                    begin
                                        mem_we = 1'b1;
                                        mem_wa = bp_reg[AW-1:0];
                                    end
                                    bp_next = bp_reg + 9'd1;
                                    if (bp_next > FB9)
                                        mode_next = LS_LONG;
                                end
                            end
                        end
                        OP_TICK:
                        begin
                            emit = 1'b1;
                            if (gap_run_reg)
                            begin
                                if (gap_cnt_reg > 16'd1)
                                    gap_cnt_next = gap_cnt_reg - 16'd1;
                                else
                                begin
                                    gap_cnt_next = 16'd0;
                                    gap_run_next = 1'b0;
                                    if (mode_reg == LS_RECV)
                                    begin
                                        mode_next = LS_IDLE;
                                        if (bp_reg >= 9'd3 && bp_reg <= FB9)
                                        begin
                                            // Run the CRC over the payload and pick
                                            // up the two trailer bytes.
                                            emit          = 1'b0;
                                            mode_next     = LS_RECV;
                                            state_next    = S_WALK;
                                            walk_chk_next = 1'b1;
                                            issue_next    = 9'd0;
                                            fold_next     = 9'd0;
                                            total_next    = bp_reg;
                                            lim_next      = bp_reg - 9'd2;
                                            wcrc_next     = 16'hFFFF;
                                        end
                                    end
                                    else if (mode_reg == LS_LONG || mode_reg == LS_LERR)
                                        mode_next = LS_IDLE;
                                    else if (mode_reg == LS_PAUSE)
                                    begin
                                        emit          = 1'b0;
                                        drv_next      = 1'b1;
                                        mode_next     = LS_DATA;
                                        mem_ra        = bp_reg[AW-1:0];
                                        bp_next       = bp_reg + 9'd1;
                                        fetch_tx_next = 1'b1;
                                        state_next    = S_FETCH;
                                    end
                                end
                            end
                        end
                        OP_TX_DONE:
                        begin
                            emit = 1'b1;
                            if (mode_reg == LS_DATA)
                            begin
                                if (bp_reg == cnt_reg)
                                begin
                                    mode_next = LS_CRCL;
                                    r_txv     = 1'b1;
                                    r_txb     = crc_reg[7:0];
                                end
                                else
                                begin
                                    emit          = 1'b0;
                                    mem_ra        = bp_reg[AW-1:0];
                                    bp_next       = bp_reg + 9'd1;
                                    fetch_tx_next = 1'b1;
                                    state_next    = S_FETCH;
                                end
                            end
                            else if (mode_reg == LS_CRCL)
                            begin
                                mode_next = LS_CRCH;
                                r_txv     = 1'b1;
                                r_txb     = crc_reg[15:8];
                            end
                            else
                            begin
                                mode_next = LS_IDLE;
                                drv_next  = 1'b0;
                                rxon_next = 1'b1;
                            end
                        end
                        OP_BUF_RD:
                        begin
                            if (q_item.index <= FB9)
                            begin
                                mem_ra        = q_item.index[AW-1:0];
                                fetch_tx_next = 1'b0;
                                state_next    = S_FETCH;
                            end
                            else
                                emit = 1'b1;
                        end
                        OP_BUF_WR:
                        begin
                            emit = 1'b1;
                            if (q_item.index <= FB9)
                            begin
                                mem_we = 1'b1;
                                mem_wa = q_item.index[AW-1:0];
                            end
                        end
                        OP_SEND:
                        begin
                            if (q_item.length == 9'd0 || q_item.length > FB9 ||
                                mode_reg != LS_READY)
                                emit = 1'b1;
                            else
                            begin
                                rxon_next     = 1'b0;
                                mode_next     = LS_PAUSE;
                                bp_next       = 9'd0;
                                cnt_next      = q_item.length;
                                gap_cnt_next  = gap_ticks_reg;
                                gap_run_next  = 1'b1;
                                state_next    = S_WALK;
                                walk_chk_next = 1'b0;
                                issue_next    = 9'd0;
                                fold_next     = 9'd0;
                                total_next    = q_item.length;
                                lim_next      = q_item.length;
                                wcrc_next     = 16'hFFFF;
                            end
                        end
                        OP_NO_REPLY:
                        begin
                            emit = 1'b1;
                            if (mode_reg == LS_READY)
                                mode_next = LS_IDLE;
                        end
                        OP_NONE:
                            emit = 1'b1;
                        default:
                            emit = 1'b1;
                    endcase
                end
            end
            S_FETCH:
            begin
                emit       = 1'b1;
                state_next = S_IDLE;
                if (fetch_tx_reg)
                begin
                    r_txv = 1'b1;
                    r_txb = rd_q;
                end
                else
                    r_rd = rd_q;
            end
            S_WALK:
            begin
                mem_ra = issue_reg[AW-1:0];
                if (issue_reg < total_reg)
                begin
                    issue_next = issue_reg + 9'd1;
                    pend_next  = 1'b1;
                end
                if (pend_reg)
                begin
                    if (fold_reg < lim_reg)
                        wcrc_next = crc16_byte(wcrc_reg, rd_q);
                    else if (fold_reg == lim_reg)
                        lo_next = rd_q;
                    else
                        hi_next = rd_q;
                    fold_next = fold_reg + 9'd1;
                end
                if (!pend_reg && fold_reg == total_reg)
                begin
                    pend_next  = 1'b0;
                    issue_next = issue_reg;
                    emit       = 1'b1;
                    state_next = S_IDLE;
                    if (walk_chk_reg)
                    begin
                        if ({hi_reg, lo_reg} == wcrc_reg)
                        begin
                            mode_next = LS_READY;
                            r_rdy     = 1'b1;
                            r_flen    = lim_reg[7:0];
                        end
                        else
                            mode_next = LS_IDLE;
                    end
                    else
                        crc_next = wcrc_reg;
                end
            end
            default:
                state_next = S_IDLE;
        endcase

        if (emit)
        begin
            out_valid_next         = 1'b1;
            out_next.link_state    = mode_next;
            out_next.tx_valid      = r_txv;
            out_next.tx_byte       = r_txb;
            out_next.driver_enable = drv_next;
            out_next.rx_enabled    = rxon_next;
            out_next.frame_ready   = r_rdy;
            out_next.frame_length  = r_flen;
            out_next.read_data     = r_rd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        rd_q <= mem[mem_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mode_reg      <= LS_IDLE;
            bp_reg        <= 9'd0;
            cnt_reg       <= 9'd0;
            crc_reg       <= 16'd0;
            gap_cnt_reg   <= 16'd0;
            gap_run_reg   <= 1'b0;
            drv_reg       <= 1'b0;
            rxon_reg      <= 1'b1;
            gap_ticks_reg <= GAP_TICKS_RESET;
            fetch_tx_reg  <= 1'b0;
            walk_chk_reg  <= 1'b0;
            issue_reg     <= 9'd0;
            fold_reg      <= 9'd0;
            total_reg     <= 9'd0;
            lim_reg       <= 9'd0;
            pend_reg      <= 1'b0;
            wcrc_reg      <= 16'd0;
            lo_reg        <= 8'd0;
            hi_reg        <= 8'd0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            bp_reg        <= bp_next;
            cnt_reg       <= cnt_next;
            crc_reg       <= crc_next;
            gap_cnt_reg   <= gap_cnt_next;
            gap_run_reg   <= gap_run_next;
            drv_reg       <= drv_next;
            rxon_reg      <= rxon_next;
            fetch_tx_reg  <= fetch_tx_next;
            walk_chk_reg  <= walk_chk_next;
            issue_reg     <= issue_next;
            fold_reg      <= fold_next;
            total_reg     <= total_next;
            lim_reg       <= lim_next;
            pend_reg      <= pend_next;
            wcrc_reg      <= wcrc_next;
            lo_reg        <= lo_next;
            hi_reg        <= hi_next;
            out_valid_reg <= out_valid_next;
            out_reg       <= out_next;
            if (cfg_wr_en)
                gap_ticks_reg <= cfg_wr_data;
        end
    end

endmodule

// ===== rtl/modbus_rtu_serial_framer_core.sv =====
// Most transactions produce their result through the output register after leaving the queue;
// buffer reads and reply bytes from the store pass through the registered store read first.
// Gap expiry on a frame and a reply start walk the store, one byte per cycle through the
// single store read port. Throughput is one item per cycle for the short requests while the
// output is accepted. Reset (rst_n, asynchronous, active low) clears link state,
// timers and queues; the frame store is not cleared.
// ----------------------------------------------------------------------------
// Modbus RTU serial framer core
// Frame receive, gap timing, CRC check and reply transmit sequencing.
// ----------------------------------------------------------------------------
module modbus_rtu_serial_framer_core
    import mbrtu_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  mbrtu_in_t   in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output mbrtu_out_t  out_data,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data
);

    // The front end decodes each transaction and holds up to two of them, so the
    // upstream side keeps moving while the engine is busy walking the store.
    logic       q_valid;
    logic       q_pop;
    mbrtu_cmd_t q_item;

    mbrtu_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_item   (q_item)
    );

    // The engine owns the frame store, the gap timer and the link state, and it
    // delivers exactly one result transaction per request through its output register.
    mbrtu_engine #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_pop       (q_pop),
        .q_item      (q_item),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

endmodule
